[hdl/assert_macros.svh]
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on clk, off while reset is asserted
`define TSS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define TSS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/tss_pkg.sv]
// Types, constants and helpers shared by the three-stack design
package tss_pkg;

	localparam int DEPTH     = 32;
	localparam int NSTACKS   = 3;
	localparam int MEM_DEPTH = NSTACKS * DEPTH;
	localparam int ADDR_W    = $clog2(MEM_DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DATA_W    = 32;

	localparam logic [1:0] CMD_PUSH = 2'd0;
	localparam logic [1:0] CMD_POP  = 2'd1;
	localparam logic [1:0] CMD_SHOW = 2'd2;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP,
		ST_SHOW
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       load_in;
		logic       do_push;
		logic       dec_cnt;
		logic       rd_issue;
		logic       rd_from_ptr;
		logic       ptr_load;
		logic       ptr_dec;
		logic       out_load;
		logic       out_src_rd;
		logic [1:0] out_status;
		logic       out_last;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] cmd;
		logic       sel_ok;
		logic       empty;
		logic       full;
		logic       ptr_zero;
		logic       out_free;
	} dp_stat_t;

	// word address of entry idx of stack sel: sel + 3*idx
	function automatic logic [ADDR_W-1:0] entry_addr(input logic [1:0] sel,
			input logic [IDX_W-1:0] idx);
		logic [ADDR_W-1:0] i;
		i = ADDR_W'(idx);
		return ADDR_W'(sel) + (i << 1) + i;
	endfunction

endpackage

[hdl/tss_ctrl.sv]
// Controller state machine for the three-stack block
module tss_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tss_pkg::dp_stat_t   stat,
	output tss_pkg::ctrl_cmd_t  cmd
);

	tss_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tss_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			tss_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = tss_pkg::ST_EXEC;
				end
			end
			tss_pkg::ST_EXEC: begin
				// drop items with an unused stack or command code
				if (!stat.sel_ok || (stat.cmd != tss_pkg::CMD_PUSH &&
						stat.cmd != tss_pkg::CMD_POP && stat.cmd != tss_pkg::CMD_SHOW)) begin
					state_d = tss_pkg::ST_IDLE;
				end else if (stat.out_free) begin
					if (stat.cmd == tss_pkg::CMD_PUSH) begin
						cmd.out_load = 1'b1;
						cmd.out_last = 1'b1;
						if (stat.full) begin
							cmd.out_status = tss_pkg::STS_FULL;
						end else begin
							cmd.do_push    = 1'b1;
							cmd.out_status = tss_pkg::STS_OK;
						end
						state_d = tss_pkg::ST_IDLE;
					end else if (stat.empty) begin
						cmd.out_load   = 1'b1;
						cmd.out_last   = 1'b1;
						cmd.out_status = tss_pkg::STS_EMPTY;
						state_d        = tss_pkg::ST_IDLE;
					end else if (stat.cmd == tss_pkg::CMD_POP) begin
						cmd.rd_issue = 1'b1;
						cmd.dec_cnt  = 1'b1;
						state_d      = tss_pkg::ST_POP;
					end else begin
						cmd.rd_issue = 1'b1;
						cmd.ptr_load = 1'b1;
						state_d      = tss_pkg::ST_SHOW;
					end
				end
			end
			tss_pkg::ST_POP: begin
				if (stat.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_src_rd = 1'b1;
					cmd.out_status = tss_pkg::STS_OK;
					cmd.out_last   = 1'b1;
					state_d        = tss_pkg::ST_IDLE;
				end
			end
			tss_pkg::ST_SHOW: begin
				// emit the fetched entry and, unless it is the bottom one, fetch the one below it
				if (stat.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_src_rd = 1'b1;
					cmd.out_status = tss_pkg::STS_OK;
					cmd.out_last   = stat.ptr_zero;
					if (stat.ptr_zero) begin
						state_d = tss_pkg::ST_IDLE;
					end else begin
						cmd.ptr_dec     = 1'b1;
						cmd.rd_issue    = 1'b1;
						cmd.rd_from_ptr = 1'b1;
					end
				end
			end
			default: begin
				state_d = tss_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[hdl/tss_dpath.sv]
// Datapath: shared store, stack counts, display pointer and output register
module tss_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tss_pkg::ctrl_cmd_t          cmd,
	output tss_pkg::dp_stat_t           stat,
	input  logic [1:0]                  in_cmd,
	input  logic [1:0]                  in_sel,
	input  logic [tss_pkg::DATA_W-1:0]  in_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tss_pkg::DATA_W-1:0]  out_data,
	output logic [1:0]                  out_status,
	output logic                        out_last
);

	logic [1:0]                  cmd_q;
	logic [1:0]                  sel_q;
	logic [tss_pkg::DATA_W-1:0]  val_q;
	logic [tss_pkg::CNT_W-1:0]   cnt_q [tss_pkg::NSTACKS];
	logic [tss_pkg::IDX_W-1:0]   ptr_q;
	logic [tss_pkg::DATA_W-1:0]  rd_q;
	logic [tss_pkg::DATA_W-1:0]  mem [tss_pkg::MEM_DEPTH];

	logic [tss_pkg::CNT_W-1:0]   cur_cnt;
	logic [tss_pkg::CNT_W-1:0]   cnt_m1;
	logic [tss_pkg::IDX_W-1:0]   top_idx;
	logic [tss_pkg::IDX_W-1:0]   ptr_m1;
	logic [tss_pkg::ADDR_W-1:0]  wr_addr;
	logic [tss_pkg::ADDR_W-1:0]  rd_addr;

	always_comb begin
		unique case (sel_q)
			2'd0:    cur_cnt = cnt_q[0];
			2'd1:    cur_cnt = cnt_q[1];
			2'd2:    cur_cnt = cnt_q[2];
			default: cur_cnt = '0;
		endcase
	end

	assign cnt_m1  = cur_cnt - tss_pkg::CNT_W'(1);
	assign top_idx = cnt_m1[tss_pkg::IDX_W-1:0];
	assign ptr_m1  = ptr_q - tss_pkg::IDX_W'(1);
	assign wr_addr = tss_pkg::entry_addr(sel_q, cur_cnt[tss_pkg::IDX_W-1:0]);
	assign rd_addr = tss_pkg::entry_addr(sel_q, cmd.rd_from_ptr ? ptr_m1 : top_idx);

	assign stat.cmd      = cmd_q;
	assign stat.sel_ok   = (sel_q != 2'd3);
	assign stat.empty    = (cur_cnt == '0);
	assign stat.full     = (cur_cnt == tss_pkg::CNT_W'(tss_pkg::DEPTH));
	assign stat.ptr_zero = (ptr_q == '0);
	assign stat.out_free = !out_valid || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q <= in_cmd;
			sel_q <= in_sel;
			val_q <= in_value;
		end
		if (cmd.do_push) begin
			mem[wr_addr] <= val_q;
		end
		if (cmd.rd_issue) begin
			rd_q <= mem[rd_addr];
		end
		if (cmd.ptr_load) begin
			ptr_q <= top_idx;
		end else if (cmd.ptr_dec) begin
			ptr_q <= ptr_m1;
		end
		if (cmd.out_load) begin
			out_data   <= cmd.out_src_rd ? rd_q : '0;
			out_status <= cmd.out_status;
			out_last   <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q[0]  <= '0;
			cnt_q[1]  <= '0;
			cnt_q[2]  <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.do_push) begin
				cnt_q[sel_q] <= cur_cnt + tss_pkg::CNT_W'(1);
			end else if (cmd.dec_cnt) begin
				cnt_q[sel_q] <= cnt_m1;
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

[hdl/three_stacks_shared_memory.sv]
// Push: the item is registered, then its result word. Pop: the item, the store read and
// the result word are registered in turn. Display: likewise for the first word, then one
// word per cycle while the output does not stall, each read from the single-port store. The
// next item is taken in the idle state, after the previous item's last word is registered.
// arst_n clears the state machine, the three stack counts and the output valid at once;
// the shared store is not cleared and is only ever read where a push has written.
`include "assert_macros.svh"

module three_stacks_shared_memory (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [tss_pkg::DATA_W-1:0]  s_tdata,   // [31:0] push_value
	input  logic [3:0]                  s_tuser,   // [1:0] command, [3:2] stack_select
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [tss_pkg::DATA_W-1:0]  m_tdata,   // [31:0] data_out
	output logic [1:0]                  m_tuser,   // [1:0] status
	output logic                        m_tlast
);

	tss_pkg::ctrl_cmd_t cmd;
	tss_pkg::dp_stat_t  stat;

	tss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tss_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_cmd     (s_tuser[1:0]),
		.in_sel     (s_tuser[3:2]),
		.in_value   (s_tdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata),
		.out_status (m_tuser),
		.out_last   (m_tlast)
	);

	`TSS_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready, "second word taken while busy")
	`TSS_ASSERT_IMP(a_no_overwrite, cmd.out_load, stat.out_free, "output word overwritten")
	`TSS_ASSERT_IMP(a_push_room, cmd.do_push, !stat.full, "push into a full stack")
	`TSS_ASSERT_IMP(a_ptr_floor, cmd.rd_issue && cmd.rd_from_ptr, !stat.ptr_zero,
		"display read below the bottom entry")

endmodule
